// ===== rtl/rdh_pkg.sv =====
// ============================================================================
// rdh_pkg
// Shared sizes, codes and pipeline types of the reuse distance histogram.
// ============================================================================
`default_nettype none

package rdh_pkg;

    // Cache geometry and statistic sizes. NUM_SETS is a power of two.
    localparam int NUM_SETS     = 2048;
    localparam int NUM_WAYS     = 16;
    localparam int MAX_DISTANCE = 64;
    localparam int COUNT_WIDTH  = 32;

    localparam int AGE_SAT   = MAX_DISTANCE + 1;
    localparam int NUM_BINS  = MAX_DISTANCE + 1;
    localparam int AGE_W     = $clog2(AGE_SAT + 1);
    localparam int BIN_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_IDX_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

    // Fixed widths of the channel fields.
    localparam int SET_FIELD_W  = 11;
    localparam int WAY_FIELD_W  = 4;
    localparam int KIND_FIELD_W = 2;
    localparam int SEL_FIELD_W  = 7;
    localparam int STAT_W       = 32;
    localparam int DIST_W       = 7;

    localparam logic FUNC_ACCESS = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    localparam logic [KIND_FIELD_W-1:0] KIND_LOAD      = 2'd0;
    localparam logic [KIND_FIELD_W-1:0] KIND_RFO       = 2'd1;
    localparam logic [KIND_FIELD_W-1:0] KIND_PREFETCH  = 2'd2;
    localparam logic [KIND_FIELD_W-1:0] KIND_WRITEBACK = 2'd3;

    localparam int SEL_OVERFLOW = MAX_DISTANCE + 1;
    localparam int SEL_HITS     = MAX_DISTANCE + 2;

    typedef logic [NUM_WAYS-1:0][AGE_W-1:0] age_row_t;
    typedef logic [COUNT_WIDTH-1:0]         count_t;

    // One request word as held in the first pipeline stage.
    typedef struct packed {
        logic                    func;
        logic [SET_FIELD_W-1:0]  set_index;
        logic [WAY_FIELD_W-1:0]  way_index;
        logic [KIND_FIELD_W-1:0] access_kind;
        logic                    was_hit;
        logic                    warmup_done;
        logic [SEL_FIELD_W-1:0]  stat_select;
    } rdh_req_t;

    // What the age stage hands to the histogram stage.
    typedef struct packed {
        logic                   is_read;
        logic [SEL_FIELD_W-1:0] sel;
        logic                   counted;
        logic [AGE_W-1:0]       age;
    } rdh_hit_t;

    // One response word.
    typedef struct packed {
        logic [STAT_W-1:0] stat_value;
        logic [DIST_W-1:0] observed_distance;
        logic              distance_valid;
    } rdh_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/rdh_if.sv =====
// ============================================================================
// rdh_if
// Valid/ready channels for request and response words.
// ============================================================================
`default_nettype none

interface rdh_req_if
    import rdh_pkg::*;
    ;
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [SET_FIELD_W-1:0]  set_index;
    logic [WAY_FIELD_W-1:0]  way_index;
    logic [KIND_FIELD_W-1:0] access_kind;
    logic                    was_hit;
    logic                    warmup_done;
    logic [SEL_FIELD_W-1:0]  stat_select;

    modport source (
        output valid, func, set_index, way_index, access_kind, was_hit,
               warmup_done, stat_select,
        input  ready
    );
    modport sink (
        input  valid, func, set_index, way_index, access_kind, was_hit,
               warmup_done, stat_select,
        output ready
    );
endinterface

interface rdh_rsp_if
    import rdh_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] stat_value;
    logic [DIST_W-1:0] observed_distance;
    logic              distance_valid;

    modport source (
        output valid, stat_value, observed_distance, distance_valid,
        input  ready
    );
    modport sink (
        input  valid, stat_value, observed_distance, distance_valid,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/rdh_age_stage.sv =====
// ============================================================================
// rdh_age_stage
// Per-set age memory: one row of way ages per set, read-modify-write with
// forwarding of the row written in the previous advance, and the clearing
// pass after reset.
// ============================================================================
`default_nettype none

module rdh_age_stage
    import rdh_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire logic             in_accept,
    input  wire logic [SET_W-1:0] in_set,
    input  wire logic             s1_valid,
    input  wire rdh_req_t         s1_item,
    output logic                  clearing,
    output rdh_hit_t              s1_info
);

    age_row_t         age_mem [NUM_SETS];
    age_row_t         row_rd_reg;
    age_row_t         fwd_row_reg;
    logic             fwd_hit_reg;
    logic             clr_reg;
    logic [SET_W-1:0] clr_cnt_reg;

    age_row_t             cur_row;
    age_row_t             inc_row;
    age_row_t             new_row;
    logic                 effective;
    logic                 wr_en;
    logic [SET_W-1:0]     s1_set;
    logic [WAY_IDX_W-1:0] s1_way;
    logic [AGE_W-1:0]     hit_age;

    assign clearing = clr_reg;
    assign s1_set   = SET_W'(s1_item.set_index);
    assign s1_way   = WAY_IDX_W'(s1_item.way_index);

    assign effective = (s1_item.func == FUNC_ACCESS)
                    && (s1_item.access_kind != KIND_WRITEBACK)
                    && s1_item.warmup_done
                    && (int'(s1_item.way_index) < NUM_WAYS);
    assign wr_en = s1_valid && adv && effective;

    always_comb
    begin
        cur_row = fwd_hit_reg ? fwd_row_reg : row_rd_reg;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (int'(cur_row[w]) < AGE_SAT)
                inc_row[w] = cur_row[w] + AGE_W'(1);
            else
                inc_row[w] = cur_row[w];
        end
        hit_age        = inc_row[s1_way];
        new_row        = inc_row;
        new_row[s1_way] = '0;
    end

    always_comb
    begin
        s1_info.is_read = (s1_item.func == FUNC_READ);
        s1_info.sel     = s1_item.stat_select;
        s1_info.counted = effective && s1_item.was_hit;
        s1_info.age     = s1_info.counted ? hit_age : '0;
    end

    // The write port is shared by the clearing pass and the pipeline.
    always_ff @(posedge clk)
    begin
        if (clr_reg)
            age_mem[clr_cnt_reg] <= '0;
        else if (wr_en)
            age_mem[s1_set] <= new_row;
        if (in_accept)
            row_rd_reg <= age_mem[in_set];
    end

    // A read issued at the same edge as a write to that set sees old data.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            fwd_row_reg <= new_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (in_accept)
                fwd_hit_reg <= wr_en && (s1_set == in_set);
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
                if (int'(clr_cnt_reg) == NUM_SETS - 1)
                    clr_reg <= 1'b0;
            end
        end
    end

    a_no_write_while_clearing : assert property (
        @(posedge clk) disable iff (!rst_n) clr_reg |-> !wr_en && !in_accept)
        else $error("pipeline touches age memory during clearing pass");

    a_counted_age_nonzero : assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid && s1_info.counted) |-> (s1_info.age != '0))
        else $error("counted hit with zero age");

    a_age_saturates : assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_valid |-> (int'(s1_info.age) <= AGE_SAT))
        else $error("age above saturation");

endmodule

`default_nettype wire

// ===== rtl/rdh_hist_stage.sv =====
// ============================================================================
// rdh_hist_stage
// Histogram bin memory with valid bits, overflow and demand hit counters,
// and response formation for the second pipeline stage.
// ============================================================================
`default_nettype none

module rdh_hist_stage
    import rdh_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     adv,
    input  wire logic     s1_valid,
    input  wire rdh_hit_t s1_info,
    input  wire logic     s2_valid,
    input  wire rdh_hit_t s2_info,
    output rdh_rsp_t      s2_rsp
);

    count_t                bin_mem [NUM_BINS];
    logic [NUM_BINS-1:0]   bin_vld_reg;
    count_t                bin_rd_reg;
    logic                  bin_rd_vld_reg;
    count_t                fwd_val_reg;
    logic                  fwd_hit_reg;
    count_t                ovf_cnt_reg;
    count_t                hit_cnt_reg;

    logic             s1_rd_en;
    logic [BIN_W-1:0] s1_addr;
    logic             s2_bin_wr;
    logic             s2_ovf;
    logic [BIN_W-1:0] s2_addr;
    count_t           cur_bin;
    count_t           bin_next;
    count_t           stat_sel;

    // Bin address: the selector for a read, the age for a counted hit.
    always_comb
    begin
        if (s1_info.is_read)
        begin
            s1_rd_en = s1_valid && (int'(s1_info.sel) <= MAX_DISTANCE);
            s1_addr  = BIN_W'(s1_info.sel);
        end
        else
        begin
            s1_rd_en = s1_valid && s1_info.counted
                    && (int'(s1_info.age) <= MAX_DISTANCE);
            s1_addr  = BIN_W'(s1_info.age);
        end
    end

    assign s2_addr   = s2_info.is_read ? BIN_W'(s2_info.sel) : BIN_W'(s2_info.age);
    assign s2_ovf    = s2_valid && s2_info.counted && (int'(s2_info.age) > MAX_DISTANCE);
    assign s2_bin_wr = s2_valid && s2_info.counted && !s2_ovf;

    always_comb
    begin
        if (fwd_hit_reg)
            cur_bin = fwd_val_reg;
        else if (bin_rd_vld_reg)
            cur_bin = bin_rd_reg;
        else
            cur_bin = '0;
        bin_next = cur_bin + COUNT_WIDTH'(1);
    end

    always_comb
    begin
        priority if (int'(s2_info.sel) <= MAX_DISTANCE)
            stat_sel = cur_bin;
        else if (int'(s2_info.sel) == SEL_OVERFLOW)
            stat_sel = ovf_cnt_reg;
        else if (int'(s2_info.sel) == SEL_HITS)
            stat_sel = hit_cnt_reg;
        else
            stat_sel = '0;
    end

    always_comb
    begin
        s2_rsp.stat_value        = s2_info.is_read ? STAT_W'(stat_sel) : '0;
        s2_rsp.observed_distance = s2_info.counted ? DIST_W'(s2_info.age) : '0;
        s2_rsp.distance_valid    = s2_info.counted;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_bin_wr)
            bin_mem[s2_addr] <= bin_next;
        if (adv && s1_rd_en)
            bin_rd_reg <= bin_mem[s1_addr];
        if (adv)
            fwd_val_reg <= bin_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_vld_reg    <= '0;
            bin_rd_vld_reg <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            ovf_cnt_reg    <= '0;
            hit_cnt_reg    <= '0;
        end
        else if (adv)
        begin
            if (s2_bin_wr)
                bin_vld_reg[s2_addr] <= 1'b1;
            bin_rd_vld_reg <= s1_rd_en && bin_vld_reg[s1_addr];
            fwd_hit_reg    <= s1_rd_en && s2_bin_wr && (s1_addr == s2_addr);
            if (s2_valid && s2_info.counted)
                hit_cnt_reg <= hit_cnt_reg + COUNT_WIDTH'(1);
            if (s2_ovf)
                ovf_cnt_reg <= ovf_cnt_reg + COUNT_WIDTH'(1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/reuse_distance_histogram.sv =====
// ============================================================================
// reuse_distance_histogram
// Set-local reuse distance profiler for last-level cache blocks.
// ============================================================================
// Usage: cache access events and statistic reads arrive as words on the req
// channel; each request gives exactly one word on the rsp channel, in order.
// An access that is not a writeback and arrives after warmup ages every way
// of its set; a hit bins the hit way's age (or counts it as overflow above
// the largest bin) and counts a demand hit; the accessed way's age clears.
// A read returns one bin, the overflow count or the demand hit count.
// The response word is formed in steps: the age row read, then the row update
// and bin read, then the bin update into the output register. One request is
// taken every cycle while req.ready is high; the per-set age row and the
// histogram bin are each read and written back at most once per word, with
// forwarding when consecutive words touch the same set or bin.
// At reset all statistics clear at once through valid bits and counters; the
// age memory is cleared one set per cycle, so req.ready stays low until every
// set is cleared. When the receiver stalls, the whole pipeline holds and
// req.ready drops in the same cycle; a waiting response is never lost.
// ============================================================================
`default_nettype none

module reuse_distance_histogram
    import rdh_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    rdh_req_if.sink      req,
    rdh_rsp_if.source    rsp
);

    logic     adv;
    logic     in_accept;
    logic     clearing;
    rdh_req_t in_item;
    rdh_req_t s1_item_reg;
    logic     s1_valid_reg;
    rdh_hit_t s1_info;
    rdh_hit_t s2_info_reg;
    logic     s2_valid_reg;
    rdh_rsp_t s2_rsp;
    rdh_rsp_t out_reg;
    logic     out_valid_reg;

    assign adv       = !out_valid_reg || rsp.ready;
    assign req.ready = adv && !clearing;
    assign in_accept = req.valid && req.ready;

    always_comb
    begin
        in_item.func        = req.func;
        in_item.set_index   = req.set_index;
        in_item.way_index   = req.way_index;
        in_item.access_kind = req.access_kind;
        in_item.was_hit     = req.was_hit;
        in_item.warmup_done = req.warmup_done;
        in_item.stat_select = req.stat_select;
    end

    rdh_age_stage u_age (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_accept (in_accept),
        .in_set    (SET_W'(req.set_index)),
        .s1_valid  (s1_valid_reg),
        .s1_item   (s1_item_reg),
        .clearing  (clearing),
        .s1_info   (s1_info)
    );

    rdh_hist_stage u_hist (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .s1_valid (s1_valid_reg),
        .s1_info  (s1_info),
        .s2_valid (s2_valid_reg),
        .s2_info  (s2_info_reg),
        .s2_rsp   (s2_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_item_reg <= in_item;
        if (adv)
        begin
            s2_info_reg <= s1_info;
            out_reg     <= s2_rsp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_accept;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.stat_value        = out_reg.stat_value;
    assign rsp.observed_distance = out_reg.observed_distance;
    assign rsp.distance_valid    = out_reg.distance_valid;

    a_no_accept_while_clearing : assert property (
        @(posedge clk) disable iff (!rst_n) clearing |-> !req.ready)
        else $error("request accepted during age memory clearing");

    a_dist_word_has_no_stat : assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.distance_valid) |-> (out_reg.stat_value == '0))
        else $error("counted hit word carries a statistic value");

    a_dist_in_range : assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.distance_valid)
            |-> (int'(out_reg.observed_distance) <= AGE_SAT)
            && (out_reg.observed_distance != '0))
        else $error("observed distance out of range");

endmodule

`default_nettype wire
